// ===== sv/prq_pkg.sv =====
// Package for the priority ready queue scheduler: default sizes, field widths,
// function and status codes, and the sequencer state type.
// No dependencies.
`default_nettype none

package prq_pkg;

	// Default sizes, handed to the top level as parameter defaults
	localparam int NUM_PRIORITIES  = 16;
	localparam int NUM_TASKS       = 32;
	localparam int RING_DEPTH      = 8;
	localparam int MAX_ACTIVATIONS = 15;

	// Fixed port field widths
	localparam int TaskIdW = 5;
	localparam int PrioInW = 5;
	localparam int LimitW  = 4;
	localparam int MaskW   = 16;
	localparam int StatusW = 2;

	typedef enum logic {
		FN_ACTIVATE = 1'b0,
		FN_DEQUEUE  = 1'b1
	} func_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK    = 2'd0,
		ST_LIMIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_ZERO  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_FIND,
		S_HEAD,
		S_SLOT
	} state_t;

endpackage

`default_nettype wire

// ===== sv/prq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module prq_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(Depth)-1:0]   waddr,
	input  logic [Width-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(Depth)-1:0]   raddr,
	output logic [Width-1:0]           rdata
);

	logic [Width-1:0] mem [Depth];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/priority_ready_queue_scheduler_core.sv =====
// Top level of the priority ready queue scheduler: sequencer, ring control,
// activation counts and task slot memories. Depends on prq_pkg and prq_ram.
//
// Usage:
//   Command channel: drive func, task_id, task_priority and activation_limit
//   and raise start; the command transfers at a rising edge with start high
//   and busy low. Every command gives exactly one result: done is high for
//   one cycle while next_task, next_idle, ready_mask and status carry it.
//   The receiver cannot stall; results are simply presented for that cycle.
//   States from the transfer edge to the result:
//     activate, or any rejected command:         EXEC
//     dequeue that leaves every ring empty:      EXEC, FIND
//     dequeue that selects a new head task:      EXEC, FIND, HEAD, SLOT
//   A new command can transfer in the cycle done is high, not before, so a
//   command is taken only once the previous one has given its result.
//   A dequeue runs a chain of memory reads: ring control read-modify-write,
//   then the control word of the top priority, then its head slot in the
//   task slot memory.
//   Reset clears the ready bitmap, the cached next task and the valid bits
//   that make the count and ring control memories read as zero; no clearing
//   pass is needed and a command can transfer right after reset.
`default_nettype none

module priority_ready_queue_scheduler_core #(
	parameter int NUM_PRIORITIES  = prq_pkg::NUM_PRIORITIES,
	parameter int NUM_TASKS       = prq_pkg::NUM_TASKS,
	parameter int RING_DEPTH      = prq_pkg::RING_DEPTH,
	parameter int MAX_ACTIVATIONS = prq_pkg::MAX_ACTIVATIONS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [prq_pkg::TaskIdW-1:0]  task_id,
	input  logic [prq_pkg::PrioInW-1:0]  task_priority,
	input  logic [prq_pkg::LimitW-1:0]   activation_limit,
	output logic                         done,
	output logic [prq_pkg::TaskIdW-1:0]  next_task,
	output logic                         next_idle,
	output logic [prq_pkg::MaskW-1:0]    ready_mask,
	output logic [prq_pkg::StatusW-1:0]  status
);

	import prq_pkg::*;

	localparam int TaskW      = $clog2(NUM_TASKS);
	localparam int PrioW      = $clog2(NUM_PRIORITIES);
	localparam int PrioVW     = $clog2(NUM_PRIORITIES + 1);
	localparam int HeadW      = $clog2(RING_DEPTH);
	localparam int FillW      = $clog2(RING_DEPTH + 1);
	localparam int CntW       = $clog2(MAX_ACTIVATIONS + 1);
	localparam int SlotDepth  = NUM_PRIORITIES * RING_DEPTH;
	localparam int SlotAw     = $clog2(SlotDepth);
	localparam int MaskExtW   = (NUM_PRIORITIES > MaskW) ? NUM_PRIORITIES : MaskW;
	localparam int TaskInNum  = 2 ** TaskIdW;

	typedef struct packed {
		logic [HeadW-1:0] head;
		logic [HeadW-1:0] tail;
		logic [FillW-1:0] fill;
	} ring_ctl_t;

	localparam int CtlW = $bits(ring_ctl_t);

	// Control state
	state_t                    state_q, state_d;
	logic [NUM_PRIORITIES-1:0] ready_q;
	logic [TaskW-1:0]          cached_q;
	logic [PrioVW-1:0]         cached_prio_q;
	status_t                   status_q;
	logic                      done_q;
	logic [NUM_TASKS-1:0]      cnt_vld_q;
	logic [NUM_PRIORITIES-1:0] ctl_vld_q;

	// Command payload
	func_t             func_q;
	logic [TaskW-1:0]  task_q;
	logic [PrioVW-1:0] prio_q;
	logic [PrioW-1:0]  p_q;
	logic [CntW-1:0]   lim_q;
	logic [PrioW-1:0]  top_q;

	// Decoded command fields
	logic              accept;
	logic [TaskW-1:0]  task_in;
	logic [PrioVW-1:0] prio_in;
	logic [PrioW-1:0]  p_in;
	logic [CntW-1:0]   lim_in;

	// Memory ports
	logic              cnt_we, cnt_re;
	logic [TaskW-1:0]  cnt_waddr, cnt_raddr;
	logic [CntW-1:0]   cnt_wdata, cnt_rdata;
	logic              ctl_we, ctl_re;
	logic [PrioW-1:0]  ctl_waddr, ctl_raddr;
	logic [CtlW-1:0]   ctl_rdata;
	ring_ctl_t         ctl_wdata;
	logic              slot_we, slot_re;
	logic [SlotAw-1:0] slot_waddr, slot_raddr;
	logic [TaskW-1:0]  slot_wdata, slot_rdata;

	// Execute stage
	logic [PrioW-1:0]          ctl_idx;
	logic [CntW-1:0]           cnt_cur, cnt_new;
	ring_ctl_t                 ctl_cur, ctl_new;
	logic [HeadW-1:0]          tail_inc, head_inc;
	logic [NUM_PRIORITIES-1:0] prio_bit, ready_deq;
	status_t                   exec_status;
	logic                      exec_ok;

	// Top priority search
	logic              any_ready;
	logic [PrioW-1:0]  top_sel;
	logic [MaskExtW-1:0] ready_ext;

	assign accept = start && (state_q == S_IDLE);

	// Command decode: id reduction, priority clamp, limit saturation
	always_comb begin
		task_in = '0;
		for (int i = 0; i < TaskInNum; i++) begin
			if (task_id == TaskIdW'(i)) begin
				task_in = TaskW'(i % NUM_TASKS);
			end
		end
		if (task_priority == '0) begin
			prio_in = PrioVW'(1);
		end else if (32'(task_priority) > NUM_PRIORITIES) begin
			prio_in = PrioVW'(NUM_PRIORITIES);
		end else begin
			prio_in = PrioVW'(task_priority);
		end
		p_in = PrioW'(prio_in - PrioVW'(1));
		if (32'(activation_limit) > MAX_ACTIVATIONS) begin
			lim_in = CntW'(MAX_ACTIVATIONS);
		end else begin
			lim_in = CntW'(activation_limit);
		end
	end

	// Entries never written read as zero
	always_comb begin
		ctl_idx = (state_q == S_HEAD) ? top_q : p_q;
		cnt_cur = cnt_vld_q[task_q] ? cnt_rdata : '0;
		ctl_cur = ctl_vld_q[ctl_idx] ? ring_ctl_t'(ctl_rdata) : '0;
	end

	// Read-modify-write of count and ring control
	always_comb begin
		prio_bit  = NUM_PRIORITIES'(1) << p_q;
		tail_inc  = (ctl_cur.tail == HeadW'(RING_DEPTH - 1)) ? '0 : ctl_cur.tail + HeadW'(1);
		head_inc  = (ctl_cur.head == HeadW'(RING_DEPTH - 1)) ? '0 : ctl_cur.head + HeadW'(1);
		cnt_new   = cnt_cur;
		ctl_new   = ctl_cur;
		ready_deq = ready_q;
		exec_status = ST_OK;
		if (func_q == FN_ACTIVATE) begin
			if (cnt_cur >= lim_q) begin
				exec_status = ST_LIMIT;
			end else if (ctl_cur.fill >= FillW'(RING_DEPTH)) begin
				exec_status = ST_FULL;
			end
			cnt_new      = cnt_cur + CntW'(1);
			ctl_new.tail = tail_inc;
			ctl_new.fill = ctl_cur.fill + FillW'(1);
		end else begin
			if (cnt_cur == '0) begin
				exec_status = ST_ZERO;
			end
			cnt_new = cnt_cur - CntW'(1);
			if (ctl_cur.fill != '0) begin
				ctl_new.head = head_inc;
				ctl_new.fill = ctl_cur.fill - FillW'(1);
			end
			if (ctl_new.fill == '0) begin
				ready_deq = ready_q & ~prio_bit;
			end
		end
		exec_ok = (state_q == S_EXEC) && (exec_status == ST_OK);
	end

	// Highest non-empty priority
	always_comb begin
		any_ready = |ready_q;
		top_sel   = '0;
		for (int i = 0; i < NUM_PRIORITIES; i++) begin
			if (ready_q[i]) begin
				top_sel = PrioW'(i);
			end
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (func_q == FN_DEQUEUE && exec_status == ST_OK) begin
					state_d = S_FIND;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FIND: begin
				state_d = any_ready ? S_HEAD : S_IDLE;
			end
			S_HEAD: state_d = S_SLOT;
			S_SLOT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and memory controls
	always_comb begin
		busy       = (state_q != S_IDLE);
		cnt_re     = accept;
		cnt_raddr  = task_in;
		cnt_we     = exec_ok;
		cnt_waddr  = task_q;
		cnt_wdata  = cnt_new;
		ctl_re     = accept || (state_q == S_FIND && any_ready);
		ctl_raddr  = (state_q == S_IDLE) ? p_in : top_sel;
		ctl_we     = exec_ok;
		ctl_waddr  = p_q;
		ctl_wdata  = ctl_new;
		slot_re    = (state_q == S_HEAD);
		slot_raddr = SlotAw'(top_q) * SlotAw'(RING_DEPTH) + SlotAw'(ctl_cur.head);
		slot_we    = exec_ok && (func_q == FN_ACTIVATE);
		slot_waddr = SlotAw'(p_q) * SlotAw'(RING_DEPTH) + SlotAw'(ctl_cur.tail);
		slot_wdata = task_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ready_q       <= '0;
			cached_q      <= '0;
			cached_prio_q <= '0;
			status_q      <= ST_OK;
			done_q        <= 1'b0;
			cnt_vld_q     <= '0;
			ctl_vld_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				S_EXEC: begin
					if (exec_ok) begin
						cnt_vld_q[task_q] <= 1'b1;
						ctl_vld_q[p_q]    <= 1'b1;
					end
					if (func_q == FN_ACTIVATE) begin
						if (exec_ok) begin
							ready_q <= ready_q | prio_bit;
							if (prio_q > cached_prio_q) begin
								cached_q      <= task_q;
								cached_prio_q <= prio_q;
							end
						end
						status_q <= exec_status;
						done_q   <= 1'b1;
					end else if (exec_ok) begin
						ready_q <= ready_deq;
					end else begin
						status_q <= exec_status;
						done_q   <= 1'b1;
					end
				end
				S_FIND: begin
					if (!any_ready) begin
						cached_q      <= '0;
						cached_prio_q <= '0;
						status_q      <= ST_OK;
						done_q        <= 1'b1;
					end
				end
				S_SLOT: begin
					cached_q      <= slot_rdata;
					cached_prio_q <= PrioVW'(top_q) + PrioVW'(1);
					status_q      <= ST_OK;
					done_q        <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Command payload and search result
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(func);
			task_q <= task_in;
			prio_q <= prio_in;
			p_q    <= p_in;
			lim_q  <= lim_in;
		end
		if (state_q == S_FIND) begin
			top_q <= top_sel;
		end
	end

	// Per-task activation counts
	prq_ram #(
		.Width (CntW),
		.Depth (NUM_TASKS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// Per-priority ring head, tail and fill
	prq_ram #(
		.Width (CtlW),
		.Depth (NUM_PRIORITIES)
	) u_ctl_ram (
		.clk   (clk),
		.we    (ctl_we),
		.waddr (ctl_waddr),
		.wdata (ctl_wdata),
		.re    (ctl_re),
		.raddr (ctl_raddr),
		.rdata (ctl_rdata)
	);

	// Ring slots, one row of RING_DEPTH per priority
	prq_ram #(
		.Width (TaskW),
		.Depth (SlotDepth)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// Result ports
	assign ready_ext  = MaskExtW'(ready_q);
	assign done       = done_q;
	assign next_task  = TaskIdW'(cached_q);
	assign next_idle  = (cached_prio_q == '0);
	assign ready_mask = ready_ext[MaskW-1:0];
	assign status     = status_q;

endmodule

`default_nettype wire

// ===== sv/prq_checker.sv =====
// Port-level checker for the priority ready queue scheduler, bound to the top.
// Depends on prq_pkg and priority_ready_queue_scheduler_core.
`default_nettype none

module prq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [prq_pkg::TaskIdW-1:0]  next_task,
	input logic                         next_idle,
	input logic [prq_pkg::MaskW-1:0]    ready_mask,
	input logic [prq_pkg::StatusW-1:0]  status
);

	// A transfer always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not raise busy");

	// A result closes the work of a command
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe without preceding work");

	// Idle results carry task zero
	a_idle_task: assert property (@(posedge clk) disable iff (!arst_n)
		(done && next_idle) |-> (next_task == '0))
		else $error("idle result with nonzero task");

	// Idle means no ready ring is shown
	a_idle_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(done && next_idle) |-> (ready_mask == '0))
		else $error("idle result with ready rings");

endmodule

bind priority_ready_queue_scheduler_core prq_checker u_prq_checker (.*);

`default_nettype wire
